>>> design/assert_macros.svh
// Assertion macros used by the checker module of the strip map block.
// Holds only macro definitions; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Checks that an antecedent is followed by a consequent a fixed number of cycles later.
`define ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("latency check failed");

`endif

>>> design/scm_pkg.sv
// Types, codes and constants of the strip to readout channel map.
// Used by every module of the block; depends on nothing.
package scm_pkg;

    typedef struct packed {
        logic        mode;
        logic [10:0] strip;
        logic [1:0]  layer;
        logic [4:0]  module_req;
        logic [3:0]  plaquette;
        logic        central;
        logic [10:0] p_channels;
        logic [10:0] n_channels;
    } t_in_beat;

    typedef struct packed {
        logic [6:0]  chip;
        logic [10:0] channel;
        logic [1:0]  status;
    } t_out_beat;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_STRIP = 2'd1;
    localparam logic [1:0] ST_NO_N  = 2'd2;
    localparam logic [1:0] ST_ADDR  = 2'd3;

    localparam logic [1:0] LAYER_CLOSER = 2'd0;
    localparam logic [1:0] LAYER_INNER  = 2'd1;
    localparam logic [1:0] LAYER_OUTER  = 2'd2;

    localparam logic MODE_P = 1'b0;
    localparam logic MODE_N = 1'b1;

    typedef enum logic [1:0] {
        RED_NONE,
        RED_640,
        RED_384
    } t_red;

    // A negative 32-bit difference wraps to a value that is 256 modulo both 640 and 384.
    localparam logic signed [12:0] WRAP_OFS = 13'sd256;
    localparam logic signed [12:0] MOD_640  = 13'sd640;
    localparam logic signed [12:0] MOD_384  = 13'sd384;

    localparam logic [6:0]  CHIP_MAX = 7'd96;
    localparam logic signed [12:0] CHAN_MAX = 13'sd1536;

    // Decoded item after the first stage.
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [6:0]  chip;
        logic        neg;
        logic [10:0] base;
        logic [10:0] strip;
        t_red        red;
        logic [9:0]  post;
    } t_dec_beat;

    // Item after the add and first fold.
    typedef struct packed {
        logic               valid;
        logic [1:0]         status;
        logic [6:0]         chip;
        logic signed [12:0] value;
        t_red               red;
        logic [9:0]         post;
    } t_fold_beat;

endpackage

>>> design/scm_decode.sv
// First stage of the strip map: range check, half and pair decode, formula selection.
// Depends on scm_pkg.
module scm_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  scm_pkg::t_in_beat i_data,
    output scm_pkg::t_dec_beat o_dec
);
    import scm_pkg::*;

    logic [10:0] max_strip;
    logic        strip_bad;
    logic        first_half;
    logic [3:0]  pair;
    logic        even;
    logic        first;
    logic [6:0]  chip_base;
    t_dec_beat   n_dec;
    t_dec_beat   r_dec;

    always_comb begin
        max_strip  = (i_data.mode == MODE_N) ? i_data.n_channels : i_data.p_channels;
        strip_bad  = (i_data.strip == 11'd0) || (i_data.strip > max_strip);
        first_half = (i_data.plaquette <= 4'd2);
        pair       = (i_data.module_req == 5'd0) ? 4'd0 : 4'((i_data.module_req - 5'd1) >> 1);
        even       = !i_data.module_req[0];
        first      = first_half ^ i_data.module_req[0];
        chip_base  = 7'd0;

        n_dec        = '0;
        n_dec.valid  = i_valid;
        n_dec.status = ST_OK;
        n_dec.strip  = i_data.strip;
        n_dec.red    = RED_NONE;

        unique case (i_data.layer)
            LAYER_OUTER: begin
                chip_base  = first_half ? 7'd47 : 7'd48;
                n_dec.chip = chip_base + {1'b0, i_data.module_req, 1'b0};
                if (i_data.mode == MODE_P) begin
                    if (first_half) begin
                        n_dec.neg  = i_data.central;
                        n_dec.base = i_data.central ? 11'd1281 : 11'd0;
                    end else begin
                        n_dec.neg  = !i_data.central;
                        n_dec.base = i_data.central ? 11'd640 : 11'd641;
                    end
                end else begin
                    n_dec.neg = 1'b1;
                    if (i_data.central) begin
                        n_dec.base = 11'd1280;
                        n_dec.red  = RED_640;
                    end else begin
                        n_dec.base = 11'd1281;
                    end
                end
            end
            LAYER_INNER: begin
                chip_base  = first_half ? 7'd25 : 7'd26;
                n_dec.chip = chip_base + {2'b0, pair, 1'b0};
                if (i_data.mode == MODE_N) begin
                    n_dec.status = ST_NO_N;
                end else if (first_half) begin
                    n_dec.base = even ? 11'd640 : 11'd0;
                end else begin
                    n_dec.neg  = 1'b1;
                    n_dec.base = even ? 11'd1281 : 11'd513;
                end
            end
            LAYER_CLOSER: begin
                chip_base  = first_half ? 7'd1 : 7'd2;
                n_dec.chip = chip_base + {2'b0, pair, 1'b0};
                if (i_data.mode == MODE_P) begin
                    if (first_half) begin
                        n_dec.neg = !i_data.central;
                        if (i_data.central) begin
                            n_dec.base = even ? 11'd1152 : 11'd384;
                        end else begin
                            n_dec.base = even ? 11'd1153 : 11'd385;
                        end
                    end else if (i_data.central) begin
                        n_dec.neg  = 1'b1;
                        n_dec.base = even ? 11'd769 : 11'd1537;
                    end else begin
                        n_dec.base = even ? 11'd0 : 11'd768;
                    end
                end else begin
                    n_dec.neg = 1'b1;
                    if (i_data.central) begin
                        n_dec.base = 11'd1152;
                        n_dec.red  = RED_384;
                        n_dec.post = first ? 10'd768 : 10'd0;
                    end else begin
                        n_dec.base = first ? 11'd1537 : 11'd769;
                    end
                end
            end
            default: begin
                // No formula for this layer code: chip stays zero and fails the address check.
                n_dec.chip = 7'd0;
            end
        endcase

        if (strip_bad) begin
            n_dec.status = ST_STRIP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec.valid <= 1'b0;
        end else begin
            r_dec.valid <= n_dec.valid;
        end
        r_dec.status <= n_dec.status;
        r_dec.chip   <= n_dec.chip;
        r_dec.neg    <= n_dec.neg;
        r_dec.base   <= n_dec.base;
        r_dec.strip  <= n_dec.strip;
        r_dec.red    <= n_dec.red;
        r_dec.post   <= n_dec.post;
    end

    assign o_dec = r_dec;

endmodule

>>> design/scm_fold.sv
// Second stage of the strip map: signed add of base and strip and the first modulo fold.
// Depends on scm_pkg.
module scm_fold (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scm_pkg::t_dec_beat  i_dec,
    output scm_pkg::t_fold_beat o_fold
);
    import scm_pkg::*;

    logic signed [12:0] sum;
    logic signed [12:0] shifted;
    logic signed [12:0] modulus;
    t_fold_beat         n_fold;
    t_fold_beat         r_fold;

    always_comb begin
        if (i_dec.neg) begin
            sum = $signed({2'b00, i_dec.base}) - $signed({2'b00, i_dec.strip});
        end else begin
            sum = $signed({2'b00, i_dec.base}) + $signed({2'b00, i_dec.strip});
        end
        modulus = (i_dec.red == RED_640) ? MOD_640 : MOD_384;
        // A wrapped difference is replaced by its residue offset before folding.
        shifted = sum[12] ? (sum + WRAP_OFS) : sum;

        n_fold        = '0;
        n_fold.valid  = i_dec.valid;
        n_fold.status = i_dec.status;
        n_fold.chip   = i_dec.chip;
        n_fold.red    = i_dec.red;
        n_fold.post   = i_dec.post;
        if (i_dec.red == RED_NONE) begin
            n_fold.value = sum;
        end else if (shifted[12]) begin
            n_fold.value = shifted + modulus;
        end else if (shifted >= modulus) begin
            n_fold.value = shifted - modulus;
        end else begin
            n_fold.value = shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold.valid <= 1'b0;
        end else begin
            r_fold.valid <= n_fold.valid;
        end
        r_fold.status <= n_fold.status;
        r_fold.chip   <= n_fold.chip;
        r_fold.value  <= n_fold.value;
        r_fold.red    <= n_fold.red;
        r_fold.post   <= n_fold.post;
    end

    assign o_fold = r_fold;

endmodule

>>> design/scm_check.sv
// Third stage of the strip map: last fold, offset, range check and the output register.
// Depends on scm_pkg.
module scm_check (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scm_pkg::t_fold_beat i_fold,
    output logic                o_valid,
    output scm_pkg::t_out_beat  o_result
);
    import scm_pkg::*;

    logic signed [12:0] folded;
    logic signed [12:0] chan;
    logic               addr_ok;
    t_out_beat          n_result;
    logic               r_valid;
    t_out_beat          r_result;

    always_comb begin
        folded = i_fold.value;
        if (i_fold.red == RED_384) begin
            if (i_fold.value[12]) begin
                folded = i_fold.value + MOD_384;
            end else if (i_fold.value >= MOD_384) begin
                folded = i_fold.value - MOD_384;
            end
        end
        if (i_fold.red == RED_NONE) begin
            chan = folded;
        end else begin
            chan = folded + $signed({3'b000, i_fold.post}) + 13'sd1;
        end

        addr_ok = (i_fold.chip != 7'd0) && (i_fold.chip <= CHIP_MAX)
            && !chan[12] && (chan != 13'sd0) && (chan <= CHAN_MAX);

        n_result = '0;
        if (i_fold.status != ST_OK) begin
            n_result.status = i_fold.status;
        end else if (!addr_ok) begin
            n_result.status = ST_ADDR;
        end else begin
            n_result.status  = ST_OK;
            n_result.chip    = i_fold.chip;
            n_result.channel = chan[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_fold.valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> design/strip_to_readout_channel_map.sv
// Top level of the strip to readout channel map: three register stages in a row.
// Depends on scm_pkg, scm_decode, scm_fold and scm_check.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start, accepted if !busy  i_data   (scm_pkg::t_in_beat)
//   result    out        o_valid strobe, 1 cycle   o_result (scm_pkg::t_out_beat)
//
// Every beat passes through the register stages in order before its result strobe:
// decode, add and fold, then final fold and range check.
// A new beat is taken at every edge: busy stays low, so one result leaves per cycle.
// Reset is synchronous and active low; it clears the valid bits of all stages,
// so beats in flight at reset are dropped. The receiver cannot stall the block.
module strip_to_readout_channel_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  scm_pkg::t_in_beat  i_data,
    output logic               o_valid,
    output scm_pkg::t_out_beat o_result
);
    import scm_pkg::*;

    t_dec_beat  dec_beat;
    t_fold_beat fold_beat;

    // The pipeline never holds off a request, since its output cannot be stalled.
    assign busy = 1'b0;

    // Stage one: strip range check, half and module pair decode, and the choice
    // of base, sign and modulo path for the selected layer and side.
    scm_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_data  (i_data),
        .o_dec   (dec_beat)
    );

    // Stage two: base plus or minus strip, then the first modulo correction.
    scm_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_dec   (dec_beat),
        .o_fold  (fold_beat)
    );

    // Stage three: the second correction of the 384 path, the chip and channel
    // range checks, and the zeroing of address fields on any error.
    scm_check u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fold   (fold_beat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

>>> design/scm_checker.sv
// Port level checker for the strip to readout channel map and its bind statement.
// Depends on scm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input scm_pkg::t_out_beat o_result
);
    import scm_pkg::*;

    logic err_beat;
    logic ok_beat;
    logic fields_zero;
    logic fields_in_range;

    assign err_beat = o_valid && (o_result.status != ST_OK);
    assign ok_beat  = o_valid && (o_result.status == ST_OK);

    // Address fields are cleared on an error and lie in the legal ranges otherwise.
    assign fields_zero     = (o_result.chip == 7'd0) && (o_result.channel == 11'd0);
    assign fields_in_range = (o_result.chip != 7'd0) && (o_result.chip <= CHIP_MAX)
        && (o_result.channel != 11'd0) && (o_result.channel <= 11'd1536);

    `ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !busy)
    `ASSERT_DELAY(a_latency, i_clk, i_rst_n, start && !busy, 3, o_valid)
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, err_beat, fields_zero)
    `ASSERT_IMPL(a_ok_range, i_clk, i_rst_n, ok_beat, fields_in_range)

endmodule

bind strip_to_readout_channel_map scm_checker u_scm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
